// File: design/pfr_pkg.sv
`default_nettype none
package pfr_pkg;

  localparam int NUM_PAGES  = 64;
  localparam int NUM_FRAMES = 16;

  localparam int PAGE_W  = 6;
  localparam int FRAME_W = 4;
  localparam int FILL_W  = 5;
  localparam int COUNT_W = 32;

  typedef struct packed {
    logic              op;
    logic [PAGE_W-1:0] page;
    logic              is_write;
  } in_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               hit;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic               write_back;
    logic [COUNT_W-1:0] fault_count;
  } out_t;

  // page table entry: frame number and flags
  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               used;
    logic               dirty;
    logic               present;
  } pte_t;

  localparam logic OP_FAULT  = 1'b0;
  localparam logic OP_ACCESS = 1'b1;

  localparam logic POLICY_FIFO  = 1'b0;
  localparam logic POLICY_CLOCK = 1'b1;

endpackage
`default_nettype wire

// File: design/page_fault_frame_replacer.sv
// Page fault frame replacer.
// Input channel in_valid/in_ready carries one transaction: op (fault or
// access), page and is_write. Output channel out_valid/out_ready returns one
// result per input transaction, in order.
// cfg_we/cfg_wdata write policy_mode (0 fifo, 1 clock second chance); write it
// only while the block is idle.
// The page table and frame owner map live in memories with registered reads,
// driven by a small sequencer; one transaction is taken at a time and the
// block is not ready until its result is loaded into the output register.
// Steps: access or fault on a present page: check, done; fault on a free
// frame: check, allocate, done; fault with eviction: check, then owner read,
// flag read and victim check for each frame visited (at most 16 more visits
// for cleared used bits), allocate, done. Each sweep step costs one owner
// map read, one page table read and a write-back of the cleared used bit.
// Reset clears all page present bits through per-entry valid flip-flops, the
// fill count, the hand and the fault counter at once; no clearing pass.
// A stalled receiver holds the result in the output register; the next
// transaction may be accepted and worked on, but its result waits until the
// register is free.
`default_nettype none
module page_fault_frame_replacer
  import pfr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_PCHK    = 7'b0000010,
    S_OWN_RD  = 7'b0000100,
    S_VFLG_RD = 7'b0001000,
    S_VCHK    = 7'b0010000,
    S_ALLOC   = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  state_t state;

  logic               policy_mode;
  in_t                item;
  out_t               res;
  out_t               res_next;
  logic [FILL_W-1:0]  frames_filled;
  logic [FRAME_W-1:0] hand;
  logic [COUNT_W-1:0] faults;
  logic [PAGE_W-1:0]  old_page;

  pte_t               page_mem [NUM_PAGES];
  logic [PAGE_W-1:0]  owner_mem [NUM_FRAMES];
  logic [NUM_PAGES-1:0] vld;

  pte_t               pm_rdata;
  logic               pm_rvld;
  logic [PAGE_W-1:0]  om_rdata;

  logic               pm_re;
  logic [PAGE_W-1:0]  pm_raddr;
  logic               pm_we;
  logic [PAGE_W-1:0]  pm_waddr;
  pte_t               pm_wdata;
  logic               om_we;

  pte_t               cur;
  logic [FRAME_W-1:0] hand_inc;
  logic [COUNT_W-1:0] faults_inc;

  assign in_ready   = (state == S_IDLE);
  assign cur        = pm_rvld ? pm_rdata : '0;
  assign hand_inc   = (hand == FRAME_W'(NUM_FRAMES - 1)) ? '0 : hand + FRAME_W'(1);
  assign faults_inc = (faults == '1) ? faults : faults + COUNT_W'(1);

  // memory port control
  always_comb begin
    pm_re    = 1'b0;
    pm_raddr = in_data.page;
    pm_we    = 1'b0;
    pm_waddr = item.page;
    pm_wdata = cur;
    om_we    = 1'b0;
    case (state)
      S_IDLE: begin
        pm_re    = in_valid;
        pm_raddr = in_data.page;
      end
      S_PCHK: begin
        if (item.op == OP_ACCESS && cur.present) begin
          pm_we         = 1'b1;
          pm_wdata      = cur;
          pm_wdata.used = 1'b1;
          if (item.is_write) begin
            pm_wdata.dirty = 1'b1;
          end
        end
      end
      S_VFLG_RD: begin
        pm_re    = 1'b1;
        pm_raddr = om_rdata;
      end
      S_VCHK: begin
        pm_we    = 1'b1;
        pm_waddr = old_page;
        if (policy_mode == POLICY_CLOCK && cur.used) begin
          pm_wdata      = cur;
          pm_wdata.used = 1'b0;
        end else begin
          pm_wdata = '0;
        end
      end
      S_ALLOC: begin
        pm_we            = 1'b1;
        pm_waddr         = item.page;
        pm_wdata         = '0;
        pm_wdata.frame   = res.frame;
        pm_wdata.present = 1'b1;
        om_we            = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // result being built for the transaction in flight
  always_comb begin
    res_next = res;
    case (state)
      S_PCHK: begin
        res_next = '0;
        if (item.op == OP_ACCESS) begin
          res_next.fault_count = faults;
          if (cur.present) begin
            res_next.hit   = 1'b1;
            res_next.frame = cur.frame;
          end
        end else begin
          res_next.fault_count = faults_inc;
          if (cur.present) begin
            res_next.frame = cur.frame;
          end else if (frames_filled < FILL_W'(NUM_FRAMES)) begin
            res_next.frame = frames_filled[FRAME_W-1:0];
          end
        end
      end
      S_VCHK: begin
        if (!(policy_mode == POLICY_CLOCK && cur.used)) begin
          res_next.frame         = hand;
          res_next.evicted_valid = 1'b1;
          res_next.evicted_page  = old_page;
          res_next.write_back    = cur.dirty;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pm_re) begin
      pm_rdata <= page_mem[pm_raddr];
      pm_rvld  <= vld[pm_raddr];
    end
    if (pm_we) begin
      page_mem[pm_waddr] <= pm_wdata;
    end
    if (state == S_OWN_RD) begin
      om_rdata <= owner_mem[hand];
    end
    if (om_we) begin
      owner_mem[res.frame] <= item.page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (pm_we) begin
      vld[pm_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode <= POLICY_CLOCK;
    end else if (cfg_we) begin
      policy_mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      frames_filled <= '0;
      hand          <= '0;
      faults        <= '0;
      out_valid     <= 1'b0;
    end else begin
      res <= res_next;
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_data;
            state <= S_PCHK;
          end
        end
        S_PCHK: begin
          if (item.op == OP_ACCESS || cur.present) begin
            if (item.op == OP_FAULT) begin
              faults <= faults_inc;
            end
            state <= S_DONE;
          end else begin
            faults <= faults_inc;
            if (frames_filled < FILL_W'(NUM_FRAMES)) begin
              frames_filled <= frames_filled + FILL_W'(1);
              state         <= S_ALLOC;
            end else begin
              state <= S_OWN_RD;
            end
          end
        end
        S_OWN_RD: begin
          state <= S_VFLG_RD;
        end
        S_VFLG_RD: begin
          old_page <= om_rdata;
          state    <= S_VCHK;
        end
        S_VCHK: begin
          hand <= hand_inc;
          if (policy_mode == POLICY_CLOCK && cur.used) begin
            // second chance: used bit cleared, move on
            state <= S_OWN_RD;
          end else begin
            state <= S_ALLOC;
          end
        end
        S_ALLOC: begin
          state <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    frames_filled <= FILL_W'(NUM_FRAMES))
    else $error("fill count beyond frame count");

  a_evict_when_full: assert property (@(posedge clk) disable iff (rst)
    state == S_OWN_RD |-> frames_filled == FILL_W'(NUM_FRAMES))
    else $error("victim search with free frames left");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.hit && out_data.evicted_valid))
    else $error("result reports both hit and eviction");

  a_wb_needs_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.write_back |-> out_data.evicted_valid)
    else $error("write-back without eviction");

  a_alloc_from_fault: assert property (@(posedge clk) disable iff (rst)
    state == S_ALLOC |-> item.op == OP_FAULT)
    else $error("frame allocated for an access");
`endif

endmodule
`default_nettype wire
